@@ hw/rtl/assert_macros.svh @@
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define PRF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, also during reset
`define PRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PRF_ASSERT(lbl, clk, rst_n, prop, msg)
`define PRF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hw/rtl/prf_fl_pkg.sv @@
`timescale 1ns / 1ps

package prf_fl_pkg;

  localparam int DEF_NUM_PHYS   = 128;
  localparam int DEF_NUM_ARCH   = 32;
  localparam int DEF_NUM_CKPT   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // link value is the address of the next instruction
  localparam int LINK_OFFSET = 4;

  localparam int PHY_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int CKPT_W   = 4;
  localparam int PC_W     = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE   = 3'd0,
    ACT_ALLOC   = 3'd1,
    ACT_FREE    = 3'd2,
    ACT_RESTORE = 3'd3,
    ACT_READ    = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_ZERO  = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

endpackage

@@ hw/rtl/phys_reg_file_free_list.sv @@
`timescale 1ns / 1ps
// a transaction is accepted only in IDLE, so not before the last one is written back;
//   it is latched and its result registered at the write-back in EXEC, which waits while
//   the output register still holds a result and follows the synchronous memory reads
// reset (asynchronous, active low): pointers, ready bits and per-entry valid bits are
//   reset at once (tail to NUM_PHYS-NUM_ARCH, only registers below NUM_ARCH ready),
//   so no clearing pass is needed; checkpoint slots are not reset
`include "assert_macros.svh"

module phys_reg_file_free_list
  import prf_fl_pkg::*;
#(
  parameter int NUM_PHYS   = DEF_NUM_PHYS,
  parameter int NUM_ARCH   = DEF_NUM_ARCH,
  parameter int NUM_CKPT   = DEF_NUM_CKPT,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata from bit 0: phy[7], value[32], ckpt_id[4], alloc_dest[1], is_link[1], pc[32],
  // zero padding[3]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser from bit 0: action[3]
  input  logic [ACTION_W-1:0]    s_axis_tuser,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata from bit 0: tag_out[7], data_out[32], ready_out[1]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser from bit 0: status[2]
  output logic [STATUS_W-1:0]    m_axis_tuser
);

  localparam int TAG_W   = $clog2(NUM_PHYS);
  localparam int PW      = $clog2(2 * NUM_PHYS);
  localparam int CK_W    = $clog2(NUM_CKPT);
  localparam int PTR_MOD = 2 * NUM_PHYS;

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  fsm_e state_q, state_d;
  logic commit;            // exec cycle that writes back and loads the output register
  logic in_acc;

  // latched input transaction (payload, no reset)
  action_e            act_q;
  logic [PHY_W-1:0]   phy_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [CKPT_W-1:0]  ck_q;
  logic               alloc_q;
  logic               link_q;
  logic [PC_W-1:0]    pc_q;

  // free-list pointers count modulo twice the list depth
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;

  // per-register ready bits and valid bits standing for the all-zero reset of values
  logic [NUM_PHYS-1:0] ready_q, ready_d;
  logic [NUM_PHYS-1:0] rv_vld_q, rv_vld_d;
  // valid bits of the free-list slots; an unwritten slot reads as its reset tag
  logic [NUM_PHYS-1:0] ft_vld_q, ft_vld_d;

  // saved heads, undefined until written
  logic [PW-1:0] sh_q [NUM_CKPT];

  // output register
  logic                 m_valid_q;
  logic [PHY_W-1:0]     out_tag_q, out_tag_d;
  logic [VALUE_W-1:0]   out_data_q, out_data_d;
  logic                 out_rdy_q, out_rdy_d;
  status_e              out_stat_q, out_stat_d;

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] rv_mem [NUM_PHYS];
  logic [TAG_W-1:0]      ft_mem [NUM_PHYS];

  logic                  rv_we;
  logic [TAG_W-1:0]      rv_waddr;
  logic [DATA_WIDTH-1:0] rv_wdata;
  logic [TAG_W-1:0]      rv_raddr;
  logic [DATA_WIDTH-1:0] rv_rdata_q;

  logic                  ft_we;
  logic [TAG_W-1:0]      ft_wdata;
  logic [TAG_W-1:0]      ft_rdata_q;

  logic [TAG_W-1:0]      head_slot, tail_slot;

  // the register read follows the incoming tag at acceptance and the held tag after
  assign rv_raddr = (state_q == FSM_IDLE) ? TAG_W'(s_axis_tdata[PHY_W-1:0])
                                          : TAG_W'(phy_q);

  always_ff @(posedge clk_i) begin
    if (rv_we) begin
      rv_mem[rv_waddr] <= rv_wdata;
    end
    rv_rdata_q <= rv_mem[rv_raddr];
  end

  // head only moves at write-back, so the head slot is read in every cycle
  always_ff @(posedge clk_i) begin
    if (ft_we) begin
      ft_mem[tail_slot] <= ft_wdata;
    end
    ft_rdata_q <= ft_mem[head_slot];
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    unique case (state_q)
      FSM_IDLE: s_axis_tready = 1'b1;
      FSM_EXEC: commit = !m_valid_q || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        commit        = 1'b0;
      end
    endcase
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // read-modify-write datapath
  // ---------------------------------------------------------------------------
  logic [PW-1:0]    head_inc, tail_inc;
  logic [PW:0]      diff;
  logic [PW:0]      fcount;
  logic             list_empty, list_full;
  logic             phy_ok, ck_ok;
  logic [TAG_W-1:0] pop_tag;
  logic [TAG_W-1:0] phy_tag;
  logic [CK_W-1:0]  ck_idx;
  logic             sh_we;
  logic [PW-1:0]    sh_wdata;

  assign head_slot = (head_q >= PW'(NUM_PHYS)) ? TAG_W'(head_q - PW'(NUM_PHYS))
                                               : TAG_W'(head_q);
  assign tail_slot = (tail_q >= PW'(NUM_PHYS)) ? TAG_W'(tail_q - PW'(NUM_PHYS))
                                               : TAG_W'(tail_q);

  assign head_inc = (head_q == PW'(PTR_MOD - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == PW'(PTR_MOD - 1)) ? '0 : tail_q + 1'b1;

  // number of free tags, modulo twice the depth
  assign diff       = {1'b0, tail_q} - {1'b0, head_q};
  assign fcount     = diff[PW] ? diff + (PW+1)'(PTR_MOD) : diff;
  assign list_empty = (head_q == tail_q);
  assign list_full  = (fcount >= (PW+1)'(NUM_PHYS));

  assign phy_ok  = (32'(phy_q) < NUM_PHYS);
  assign ck_ok   = (32'(ck_q) < NUM_CKPT);
  assign phy_tag = TAG_W'(phy_q);
  assign ck_idx  = CK_W'(ck_q);

  // tag at the head; an unwritten slot holds its tag from reset
  always_comb begin
    if (ft_vld_q[head_slot]) begin
      pop_tag = ft_rdata_q;
    end else if (32'(head_slot) < NUM_PHYS - NUM_ARCH) begin
      pop_tag = TAG_W'(32'(head_slot) + NUM_ARCH);
    end else begin
      pop_tag = '0;
    end
  end

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    ready_d    = ready_q;
    rv_vld_d   = rv_vld_q;
    ft_vld_d   = ft_vld_q;
    rv_we      = 1'b0;
    rv_waddr   = phy_tag;
    rv_wdata   = DATA_WIDTH'(value_q);
    ft_we      = 1'b0;
    ft_wdata   = phy_tag;
    sh_we      = 1'b0;
    sh_wdata   = head_q;
    out_tag_d  = '0;
    out_data_d = '0;
    out_rdy_d  = 1'b0;
    out_stat_d = STAT_OK;

    if (commit) begin
      unique case (act_q)
        ACT_WRITE: begin
          if (phy_ok) begin
            rv_we             = 1'b1;
            rv_vld_d[phy_tag] = 1'b1;
            ready_d[phy_tag]  = 1'b1;
          end
        end
        ACT_ALLOC: begin
          if (alloc_q && list_empty) begin
            out_stat_d = STAT_EMPTY;
          end else if (alloc_q) begin
            head_d           = head_inc;
            sh_wdata         = head_inc;
            ready_d[pop_tag] = link_q;
            out_tag_d        = PHY_W'(pop_tag);
            // link instructions get the return address in the new register
            if (link_q) begin
              rv_we             = 1'b1;
              rv_waddr          = pop_tag;
              rv_wdata          = DATA_WIDTH'(pc_q) + DATA_WIDTH'(LINK_OFFSET);
              rv_vld_d[pop_tag] = 1'b1;
            end
          end
          sh_we = ck_ok;
        end
        ACT_FREE: begin
          if (phy_q == '0) begin
            out_stat_d = STAT_ZERO;
          end else if (phy_ok) begin
            if (list_full) begin
              out_stat_d = STAT_FULL;
            end else begin
              ft_we               = 1'b1;
              ft_vld_d[tail_slot] = 1'b1;
              tail_d              = tail_inc;
            end
          end
        end
        ACT_RESTORE: begin
          if (ck_ok) begin
            head_d = sh_q[ck_idx];
          end
        end
        ACT_READ: begin
          if (phy_ok) begin
            out_data_d = rv_vld_q[phy_tag] ? rv_rdata_q[VALUE_W-1:0] : '0;
            out_rdy_d  = ready_q[phy_tag];
          end
        end
        default: begin
          // undefined actions leave the state alone and return zeros
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      head_q    <= '0;
      tail_q    <= PW'(NUM_PHYS - NUM_ARCH);
      rv_vld_q  <= '0;
      ft_vld_q  <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PHYS; i++) begin
        ready_q[i] <= (i < NUM_ARCH);
      end
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      ready_q  <= ready_d;
      rv_vld_q <= rv_vld_d;
      ft_vld_q <= ft_vld_d;
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q   <= action_e'(s_axis_tuser);
      phy_q   <= s_axis_tdata[6:0];
      value_q <= s_axis_tdata[38:7];
      ck_q    <= s_axis_tdata[42:39];
      alloc_q <= s_axis_tdata[43];
      link_q  <= s_axis_tdata[44];
      pc_q    <= s_axis_tdata[76:45];
    end
  end

  // checkpoint slots
  always_ff @(posedge clk_i) begin
    if (sh_we) begin
      sh_q[ck_idx] <= sh_wdata;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_tag_q  <= out_tag_d;
      out_data_q <= out_data_d;
      out_rdy_q  <= out_rdy_d;
      out_stat_q <= out_stat_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_rdy_q, out_data_q, out_tag_q};
  assign m_axis_tuser  = out_stat_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `PRF_ASSERT(a_acc_to_exec, clk_i, rst_ni, in_acc |=> (state_q == FSM_EXEC), "accepted transaction not executed")
  `PRF_ASSERT(a_commit_out, clk_i, rst_ni, commit |=> m_axis_tvalid, "write-back without result")
  `PRF_ASSERT(a_tail_range, clk_i, rst_ni, (PW+1)'(tail_q) < (PW+1)'(PTR_MOD), "tail pointer out of range")
  `PRF_ASSERT(a_no_commit_idle, clk_i, rst_ni, (state_q == FSM_IDLE) |-> !commit, "write-back with no transaction held")

endmodule
